/* src/assert_macros.svh */
// Assertion macros shared by the sleep deadline queue RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define SDQ_CHECK(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define SDQ_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* src/sdq_pkg.sv */
// Shared constants, codes and types of the sleep deadline queue.
package sdq_pkg;

  localparam int SLOTS  = 16;
  localparam int IDX_W  = $clog2(SLOTS);
  localparam int OCC_W  = $clog2(SLOTS + 1);

  localparam int KIND_W = 2;
  localparam int TASK_W = 16;
  localparam int TICK_W = 64;
  localparam int DUR_W  = 32;
  localparam int SEC_W  = 20;
  localparam int EV_W   = 3;
  localparam int FREQ_W = 34;

  // total nanoseconds of a sleep fit in 50 bits
  localparam int TOT_W  = 50;
  localparam int REM_W  = 30;
  localparam int CNT_W  = $clog2(TOT_W + 1);
  localparam int MSL_W  = FREQ_W + 10;

  // long division of the product in 16-bit digits, six digits in all
  localparam int DIG_W  = 16;
  localparam int DIG_N  = 6;
  localparam int DVD_W  = DIG_W * DIG_N;
  localparam int V_W    = REM_W + DIG_W;
  localparam int VH_W   = 32;
  localparam int RCP_W  = 27;
  localparam int EST_W  = VH_W + RCP_W;

  localparam logic [REM_W-1:0]  US_PER_S  = 30'd1000000;
  localparam logic [REM_W-1:0]  NS_PER_S  = 30'd1000000000;
  localparam logic [DUR_W-1:0]  NS_PER_MS = 32'd1000000;
  localparam logic [MSL_W-1:0]  MS_PER_S  = 44'd1000;
  localparam logic [FREQ_W-1:0] FREQ_RESET = 34'd1000000000;

  // floor(2^46 / divisor): digit estimate is (top 32 bits * RCP) >> 32
  localparam logic [RCP_W-1:0]  RCP_US = 27'd70368744;
  localparam logic [RCP_W-1:0]  RCP_NS = 27'd70368;

  localparam logic [KIND_W-1:0] KIND_SLEEP_US = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SLEEP_NS = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SCAN     = 2'd2;
  localparam logic [KIND_W-1:0] KIND_DETACH   = 2'd3;

  localparam logic [EV_W-1:0] EV_QUEUED     = 3'd0;
  localparam logic [EV_W-1:0] EV_FULL       = 3'd1;
  localparam logic [EV_W-1:0] EV_NOT_QUEUED = 3'd2;
  localparam logic [EV_W-1:0] EV_WOKEN      = 3'd3;
  localparam logic [EV_W-1:0] EV_ARM        = 3'd4;
  localparam logic [EV_W-1:0] EV_DETACHED   = 3'd5;
  localparam logic [EV_W-1:0] EV_NOT_FOUND  = 3'd6;
  localparam logic [EV_W-1:0] EV_SCAN_DONE  = 3'd7;

  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 64;
  localparam logic REG_FREQ = 1'b0;
  localparam logic REG_QEN  = 1'b1;

  localparam int QDEPTH = 2;
  localparam int QP_W   = $clog2(QDEPTH);
  localparam int QC_W   = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [FREQ_W-1:0] tick_frequency;
    logic              queueing_enabled;
  } cfg_t;

  // classified request handed from front to back
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [TASK_W-1:0] task_id;
    logic [TICK_W-1:0] now_ticks;
    logic [TICK_W-1:0] deadline;
    logic [TICK_W-1:0] arm_ticks;
    logic              fine_arm;
  } op_t;

endpackage

/* src/sdq_ifs.sv */
// Request and result channel interfaces of the sleep deadline queue.
interface sdq_item_if import sdq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [TASK_W-1:0] task_id;
  logic [TICK_W-1:0] now_ticks;
  logic [DUR_W-1:0]  duration;
  logic [SEC_W-1:0]  whole_seconds;

  modport source (output valid, kind, task_id, now_ticks, duration, whole_seconds,
                  input ready);
  modport sink (input valid, kind, task_id, now_ticks, duration, whole_seconds,
                output ready);
endinterface

interface sdq_result_if import sdq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [EV_W-1:0]   event_res;
  logic [TASK_W-1:0] task_id_out;
  logic [TICK_W-1:0] timer_ticks;
  logic              last;

  modport source (output valid, event_res, task_id_out, timer_ticks, last, input ready);
  modport sink (input valid, event_res, task_id_out, timer_ticks, last, output ready);
endinterface

/* src/sdq_cfg.sv */
// APB register file: tick frequency and queueing enable.
module sdq_cfg import sdq_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  logic wr;
  logic reg_idx;

  assign wr      = psel && penable && pwrite;
  assign reg_idx = paddr[APB_ADDR_W-1];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tick_frequency   <= FREQ_RESET;
      cfg.queueing_enabled <= 1'b1;
    end else if (wr) begin
      case (reg_idx)
        REG_FREQ: cfg.tick_frequency   <= pwdata[FREQ_W-1:0];
        REG_QEN:  cfg.queueing_enabled <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_FREQ: prdata = {{(APB_DATA_W-FREQ_W){1'b0}}, cfg.tick_frequency};
      REG_QEN:  prdata = {{(APB_DATA_W-1){1'b0}}, cfg.queueing_enabled};
      default:  prdata = '0;
    endcase
  end

endmodule

/* src/sdq_fifo.sv */
// Short request queue between the front and back parts.
`include "assert_macros.svh"
module sdq_fifo import sdq_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  op_t  push_data,
  output logic pop_valid,
  input  logic pop_ready,
  output op_t  pop_data
);

  op_t             mem [QDEPTH];
  logic [QP_W-1:0] wr_ptr;
  logic [QP_W-1:0] rd_ptr;
  logic [QC_W-1:0] count;
  logic            push;
  logic            pop;

  assign push_ready = (count != QC_W'(QDEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = mem[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QP_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QP_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `SDQ_CHECK(a_fifo_bound, count <= QC_W'(QDEPTH), "queue count over depth")

endmodule

/* src/sdq_front.sv */
// Front part: takes requests, converts sleep durations to deadlines.
module sdq_front import sdq_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  sdq_item_if.sink  items,
  input  cfg_t      cfg,
  output logic      op_valid,
  input  logic      op_ready,
  output op_t       op_data
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PREP = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_DEST = 3'd3;
  localparam logic [2:0] ST_DSUB = 3'd4;
  localparam logic [2:0] ST_DCOR = 3'd5;
  localparam logic [2:0] ST_FIN  = 3'd6;

  logic [2:0]        state;
  logic [KIND_W-1:0] kind_r;
  logic [TASK_W-1:0] task_r;
  logic [TICK_W-1:0] now_r;
  logic [DUR_W-1:0]  dur_r;
  logic [SEC_W-1:0]  secs_r;
  logic              fine_r;
  logic [TOT_W-1:0]  total;
  logic [DVD_W-1:0]  prod;
  logic [REM_W-1:0]  rem;
  logic [REM_W+1:0]  rem0;
  logic [DIG_W-1:0]  qe;
  logic [TICK_W-1:0] quo;
  logic [CNT_W-1:0]  cnt;

  logic              accept;
  logic [TOT_W-1:0]  secs_ns;
  logic [REM_W-1:0]  divisor;
  logic [RCP_W-1:0]  rcp;
  logic [V_W-1:0]    v;
  logic [EST_W-1:0]  est;
  logic [V_W-1:0]    sub;
  logic [REM_W+1:0]  d1;
  logic [REM_W+1:0]  d2;
  logic [REM_W-1:0]  rem_fix;
  logic [DIG_W-1:0]  qd;
  logic [TICK_W:0]   sum;
  logic [TICK_W-1:0] deadline;

  assign items.ready = (state == ST_IDLE) && !op_valid;
  assign accept      = items.valid && items.ready;

  assign secs_ns  = TOT_W'(secs_r) * TOT_W'(NS_PER_S);
  assign divisor  = (kind_r == KIND_SLEEP_NS) ? NS_PER_S : US_PER_S;
  assign rcp      = (kind_r == KIND_SLEEP_NS) ? RCP_NS : RCP_US;

  // one digit step: partial remainder joined with the next 16 product bits
  assign v   = {rem, prod[DVD_W-1 -: DIG_W]};
  // estimate is low by at most two
  assign est = EST_W'(v[V_W-1 -: VH_W]) * EST_W'(rcp);
  assign sub = v - V_W'(qe) * V_W'(divisor);
  assign d1  = (REM_W+2)'(divisor);
  assign d2  = (REM_W+2)'({divisor, 1'b0});

  always_comb begin
    if (rem0 >= d2) begin
      rem_fix = REM_W'(rem0 - d2);
      qd      = qe + DIG_W'(2);
    end else if (rem0 >= d1) begin
      rem_fix = REM_W'(rem0 - d1);
      qd      = qe + DIG_W'(1);
    end else begin
      rem_fix = REM_W'(rem0);
      qd      = qe;
    end
  end

  assign sum      = {1'b0, now_r} + {1'b0, quo};
  // deadline saturates at the top of the counter
  assign deadline = sum[TICK_W] ? '1 : sum[TICK_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      op_valid <= 1'b0;
    end else begin
      if (op_valid && op_ready) begin
        op_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (items.kind == KIND_SCAN || items.kind == KIND_DETACH) begin
              op_valid <= 1'b1;
            end else begin
              state <= ST_PREP;
            end
          end
        end
        ST_PREP: state <= ST_MUL;
        ST_MUL: begin
          if (cnt == CNT_W'(1)) begin
            state <= ST_DEST;
          end
        end
        ST_DEST: state <= ST_DSUB;
        ST_DSUB: state <= ST_DCOR;
        ST_DCOR: begin
          if (cnt == CNT_W'(1)) begin
            state <= ST_FIN;
          end else begin
            state <= ST_DEST;
          end
        end
        ST_FIN: begin
          op_valid <= 1'b1;
          state    <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          kind_r            <= items.kind;
          task_r            <= items.task_id;
          now_r             <= items.now_ticks;
          dur_r             <= items.duration;
          secs_r            <= items.whole_seconds;
          op_data.kind      <= items.kind;
          op_data.task_id   <= items.task_id;
          op_data.now_ticks <= items.now_ticks;
          op_data.deadline  <= '0;
          op_data.arm_ticks <= '0;
          op_data.fine_arm  <= 1'b0;
        end
      end
      ST_PREP: begin
        total  <= (kind_r == KIND_SLEEP_NS) ? secs_ns + TOT_W'(dur_r) : TOT_W'(dur_r);
        fine_r <= (kind_r == KIND_SLEEP_NS) && (secs_r == '0) && (dur_r < NS_PER_MS);
        prod   <= '0;
        cnt    <= CNT_W'(TOT_W);
      end
      ST_MUL: begin
        // shift-add, MSB of the duration first
        prod  <= {prod[DVD_W-2:0], 1'b0}
                 + (total[TOT_W-1] ? DVD_W'(cfg.tick_frequency) : '0);
        total <= {total[TOT_W-2:0], 1'b0};
        cnt   <= (cnt == CNT_W'(1)) ? CNT_W'(DIG_N) : cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          rem <= '0;
          quo <= '0;
        end
      end
      ST_DEST: begin
        qe <= est[VH_W + DIG_W - 1:VH_W];
      end
      ST_DSUB: begin
        rem0 <= sub[REM_W+1:0];
      end
      ST_DCOR: begin
        rem  <= rem_fix;
        quo  <= {quo[TICK_W-DIG_W-1:0], qd};
        prod <= {prod[DVD_W-DIG_W-1:0], {DIG_W{1'b0}}};
        cnt  <= cnt - 1'b1;
      end
      ST_FIN: begin
        op_data.kind      <= kind_r;
        op_data.task_id   <= task_r;
        op_data.now_ticks <= now_r;
        op_data.deadline  <= deadline;
        op_data.arm_ticks <= deadline - now_r;
        op_data.fine_arm  <= fine_r;
      end
      default: ;
    endcase
  end

endmodule

/* src/sdq_back.sv */
// Back part: slot table, scan, detach and result register.
`include "assert_macros.svh"
module sdq_back import sdq_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         op_valid,
  output logic         op_ready,
  input  op_t          op_data,
  input  cfg_t         cfg,
  sdq_result_if.source results
);

  localparam logic [2:0] B_IDLE  = 3'd0;
  localparam logic [2:0] B_SLEEP = 3'd1;
  localparam logic [2:0] B_ARM   = 3'd2;
  localparam logic [2:0] B_SCAN  = 3'd3;
  localparam logic [2:0] B_DET   = 3'd4;

  logic [TASK_W-1:0] slot_task     [SLOTS];
  logic [TICK_W-1:0] slot_deadline [SLOTS];
  logic              slot_fine     [SLOTS];

  logic [2:0]        state;
  logic [2:0]        state_next;
  logic [OCC_W-1:0]  occ;
  logic [OCC_W-1:0]  idx;
  logic [OCC_W-1:0]  idx_next;
  op_t               cur;

  logic              res_valid;
  logic [EV_W-1:0]   res_event;
  logic [TASK_W-1:0] res_task;
  logic [TICK_W-1:0] res_ticks;
  logic              res_last;

  logic              out_free;
  logic              emit;
  logic [EV_W-1:0]   ev;
  logic [TASK_W-1:0] ev_task;
  logic [TICK_W-1:0] ev_ticks;
  logic              ev_last;
  logic              wr_en;
  logic              rm_en;

  logic [IDX_W-1:0]  cur_idx;
  logic [TASK_W-1:0] e_task;
  logic [TICK_W-1:0] e_deadline;
  logic              e_fine;
  logic [TICK_W-1:0] left;
  logic [MSL_W-1:0]  left_ms;
  logic              in_range;
  logic              due;
  logic              arm_ok;

  assign results.valid       = res_valid;
  assign results.event_res   = res_event;
  assign results.task_id_out = res_task;
  assign results.timer_ticks = res_ticks;
  assign results.last        = res_last;

  assign out_free = !res_valid || results.ready;
  assign op_ready = (state == B_IDLE);

  assign cur_idx    = idx[IDX_W-1:0];
  assign e_task     = slot_task[cur_idx];
  assign e_deadline = slot_deadline[cur_idx];
  assign e_fine     = slot_fine[cur_idx];
  assign in_range   = (idx < occ);
  assign due        = (e_deadline <= cur.now_ticks);
  assign left       = e_deadline - cur.now_ticks;
  assign left_ms    = MSL_W'(left[FREQ_W-1:0]) * MS_PER_S;
  assign arm_ok     = e_fine && (left[TICK_W-1:FREQ_W] == '0)
                      && (left_ms < MSL_W'(cfg.tick_frequency));

  always_comb begin
    state_next = state;
    idx_next   = idx;
    emit       = 1'b0;
    ev         = EV_QUEUED;
    ev_task    = cur.task_id;
    ev_ticks   = '0;
    ev_last    = 1'b1;
    wr_en      = 1'b0;
    rm_en      = 1'b0;
    case (state)
      B_IDLE: begin
        if (op_valid) begin
          idx_next = '0;
          case (op_data.kind)
            KIND_SCAN:   state_next = B_SCAN;
            KIND_DETACH: state_next = B_DET;
            default:     state_next = B_SLEEP;
          endcase
        end
      end
      B_SLEEP: begin
        if (out_free) begin
          emit       = 1'b1;
          state_next = B_IDLE;
          if (!cfg.queueing_enabled) begin
            ev = EV_NOT_QUEUED;
          end else if (occ == OCC_W'(SLOTS)) begin
            ev = EV_FULL;
          end else begin
            wr_en   = 1'b1;
            ev      = EV_QUEUED;
            ev_last = !cur.fine_arm;
            if (cur.fine_arm) begin
              state_next = B_ARM;
            end
          end
        end
      end
      B_ARM: begin
        if (out_free) begin
          emit       = 1'b1;
          ev         = EV_ARM;
          ev_ticks   = cur.arm_ticks;
          state_next = B_IDLE;
        end
      end
      B_SCAN: begin
        ev_task = e_task;
        ev_last = 1'b0;
        if (in_range) begin
          if (due) begin
            if (out_free) begin
              emit  = 1'b1;
              ev    = EV_WOKEN;
              rm_en = 1'b1;
            end
          end else if (arm_ok) begin
            if (out_free) begin
              emit     = 1'b1;
              ev       = EV_ARM;
              ev_ticks = left;
              idx_next = idx + 1'b1;
            end
          end else begin
            idx_next = idx + 1'b1;
          end
        end else if (out_free) begin
          emit       = 1'b1;
          ev         = EV_SCAN_DONE;
          ev_task    = '0;
          ev_last    = 1'b1;
          state_next = B_IDLE;
        end
      end
      B_DET: begin
        if (in_range) begin
          if (e_task == cur.task_id) begin
            if (out_free) begin
              emit       = 1'b1;
              ev         = EV_DETACHED;
              rm_en      = 1'b1;
              state_next = B_IDLE;
            end
          end else begin
            idx_next = idx + 1'b1;
          end
        end else if (out_free) begin
          emit       = 1'b1;
          ev         = EV_NOT_FOUND;
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      occ       <= '0;
      idx       <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      if (wr_en) begin
        occ <= occ + 1'b1;
      end else if (rm_en) begin
        occ <= occ - 1'b1;
      end
      if (emit) begin
        res_valid <= 1'b1;
      end else if (results.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == B_IDLE && op_valid) begin
      cur <= op_data;
    end
    if (emit) begin
      res_event <= ev;
      res_task  <= ev_task;
      res_ticks <= ev_ticks;
      res_last  <= ev_last;
    end
  end

  // table: append at occ, removal closes the gap
  always_ff @(posedge clk) begin
    for (int j = 0; j < SLOTS - 1; j++) begin
      if (rm_en && OCC_W'(j) >= idx && OCC_W'(j + 1) < occ) begin
        slot_task[j]     <= slot_task[j + 1];
        slot_deadline[j] <= slot_deadline[j + 1];
        slot_fine[j]     <= slot_fine[j + 1];
      end
    end
    if (wr_en) begin
      slot_task[occ[IDX_W-1:0]]     <= cur.task_id;
      slot_deadline[occ[IDX_W-1:0]] <= cur.deadline;
      slot_fine[occ[IDX_W-1:0]]     <= (cur.kind == KIND_SLEEP_NS);
    end
  end

  `SDQ_CHECK(a_occ_bound, occ <= OCC_W'(SLOTS), "occupancy over table size")
  `SDQ_CHECK(a_occ_step, (occ == $past(occ)) || (occ == $past(occ) + 1'b1) || (occ + 1'b1 == $past(occ)), "occupancy jumped")
  `SDQ_NEXT(a_full_reply, (state == B_SLEEP) && out_free && cfg.queueing_enabled && (occ == OCC_W'(SLOTS)), res_valid && (res_event == EV_FULL) && res_last, "full table not reported")
  `SDQ_CHECK(a_emit_room, !emit || out_free, "result overwrote a pending one")

endmodule

/* src/sleep_deadline_queue.sv */
// Top level of the sleep deadline queue.
//
//   channel   dir  protocol        contents
//   items     in   valid/ready     kind, task_id, now_ticks, duration, whole_seconds
//   results   out  valid/ready     event_res, task_id_out, timer_ticks, last
//   apb       in   APB write/read  tick_frequency @0x0, queueing_enabled @0x8
//
// Sleep requests pass the front after acceptance in order: a setup step,
// shift-add steps for frequency times duration, a division by 10^6 or 10^9
// (six 16-bit digits, each by reciprocal estimate, back-multiply and
// correction), then the saturating deadline add as the op is registered.
// Scan and detach pass the front without conversion. In the back, each request
// leaves the queue; then a sleep replies (with an arm after it for a fine
// sleep), a scan visits the slots and ends with scan_done, and a detach visits
// the slots up to the match and then gives its reply.
// Reset is synchronous; it empties the table and queue and restores registers.
// A stalled result register halts the back; the two-deep request queue lets
// the front keep converting until the queue fills.
module sleep_deadline_queue import sdq_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  sdq_item_if.sink              items,
  sdq_result_if.source          results,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t cfg;
  logic f_valid;
  logic f_ready;
  op_t  f_data;
  logic b_valid;
  logic b_ready;
  op_t  b_data;

  // register file
  sdq_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // classify and convert
  sdq_front u_front (
    .clk      (clk),
    .rst      (rst),
    .items    (items),
    .cfg      (cfg),
    .op_valid (f_valid),
    .op_ready (f_ready),
    .op_data  (f_data)
  );

  // decoupling queue
  sdq_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_data),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_data   (b_data)
  );

  // table owner and result generator
  sdq_back u_back (
    .clk      (clk),
    .rst      (rst),
    .op_valid (b_valid),
    .op_ready (b_ready),
    .op_data  (b_data),
    .cfg      (cfg),
    .results  (results)
  );

endmodule

/* sim/sdq_checker.sv */
// Result checker for the sleep deadline queue: tracks requests, predicts and compares events.
`timescale 1ns / 100ps
module sdq_checker import sdq_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  sdq_item_if                   items,
  sdq_result_if                 results,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output int                    errors,
  output int                    pending
);

  typedef struct packed {
    logic [EV_W-1:0]   ev;
    logic [TASK_W-1:0] task_id;
    logic [TICK_W-1:0] ticks;
    logic              last;
  } sdq_event_t;

  sdq_event_t        due_events[$];
  logic [FREQ_W-1:0] freq_m;
  logic              qen_m;
  logic [TASK_W-1:0] sleeper_task[SLOTS];
  logic [TICK_W-1:0] sleeper_deadline[SLOTS];
  logic              sleeper_fine[SLOTS];
  int                sleepers;

  assign pending = due_events.size();

  task automatic report(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    errors++;
  endtask

  task automatic push_event(input logic [EV_W-1:0] ev, input logic [TASK_W-1:0] t,
                            input logic [TICK_W-1:0] ticks);
    sdq_event_t e;
    e = '{ev: ev, task_id: t, ticks: ticks, last: 1'b0};
    due_events.push_back(e);
  endtask

  task automatic drop_sleeper(input int idx);
    for (int j = idx; j + 1 < sleepers; j++) begin
      sleeper_task[j]     = sleeper_task[j+1];
      sleeper_deadline[j] = sleeper_deadline[j+1];
      sleeper_fine[j]     = sleeper_fine[j+1];
    end
    sleepers--;
  endtask

  // Works out the events one request causes and updates the sleeper table.
  task automatic apply_request(input logic [KIND_W-1:0] kind, input logic [TASK_W-1:0] t,
                               input logic [TICK_W-1:0] now, input logic [DUR_W-1:0] dur,
                               input logic [SEC_W-1:0] secs);
    logic [63:0] f, d64, ticks, whole, part, deadline, left;
    logic [64:0] sum;
    logic        fine, found;
    int          i;
    f = 64'(freq_m);
    d64 = 64'(dur);
    fine = 1'b0;
    found = 1'b0;
    case (kind)
      KIND_SLEEP_US, KIND_SLEEP_NS: begin
        if (!qen_m) begin
          push_event(EV_NOT_QUEUED, t, '0);
        end else if (sleepers >= SLOTS) begin
          push_event(EV_FULL, t, '0);
        end else begin
          if (kind == KIND_SLEEP_US) begin
            ticks = (f / 64'd1000000) * d64 + ((f % 64'd1000000) * d64) / 64'd1000000;
          end else begin
            whole = 64'(secs) + d64 / 64'd1000000000;
            part  = d64 % 64'd1000000000;
            ticks = f * whole + (f * part) / 64'd1000000000;
            fine  = (secs == 0) && (dur < NS_PER_MS);
          end
          sum = {1'b0, now} + {1'b0, ticks};
          deadline = sum[64] ? '1 : sum[63:0];
          sleeper_task[sleepers]     = t;
          sleeper_deadline[sleepers] = deadline;
          sleeper_fine[sleepers]     = (kind == KIND_SLEEP_NS);
          sleepers++;
          push_event(EV_QUEUED, t, '0);
          if (fine) push_event(EV_ARM, t, deadline - now);
        end
      end
      KIND_SCAN: begin
        i = 0;
        while (i < sleepers) begin
          if (sleeper_deadline[i] <= now) begin
            push_event(EV_WOKEN, sleeper_task[i], '0);
            drop_sleeper(i);
          end else begin
            left = sleeper_deadline[i] - now;
            // fine sleeper with under 1 ms left re-arms; compare without wrap
            if (sleeper_fine[i] && left <= 64'h3_FFFF_FFFF && left * 64'd1000 < f)
              push_event(EV_ARM, sleeper_task[i], left);
            i++;
          end
        end
        push_event(EV_SCAN_DONE, '0, '0);
      end
      default: begin
        for (i = 0; i < sleepers && !found; i++) begin
          if (sleeper_task[i] == t) begin
            drop_sleeper(i);
            found = 1'b1;
          end
        end
        push_event(found ? EV_DETACHED : EV_NOT_FOUND, t, '0);
      end
    endcase
    due_events[$].last = 1'b1;
  endtask

  always @(posedge clk) begin
    sdq_event_t want;
    if (rst) begin
      freq_m   <= FREQ_RESET;
      qen_m    <= 1'b1;
      sleepers = 0;
      errors   = 0;
      due_events.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == 4'(8 * REG_FREQ)) freq_m <= pwdata[FREQ_W-1:0];
        else if (paddr == 4'(8 * REG_QEN)) qen_m <= pwdata[0];
      end
      if (items.valid && items.ready)
        apply_request(items.kind, items.task_id, items.now_ticks, items.duration,
                      items.whole_seconds);
      if (results.valid && results.ready) begin
        if (due_events.size() == 0) begin
          report("result with nothing expected");
        end else begin
          want = due_events.pop_front();
          if (results.event_res !== want.ev)
            report($sformatf("event %0d, expected %0d", results.event_res, want.ev));
          if (results.task_id_out !== want.task_id)
            report($sformatf("task %0d, expected %0d", results.task_id_out, want.task_id));
          if (results.timer_ticks !== want.ticks)
            report($sformatf("ticks %0d, expected %0d", results.timer_ticks, want.ticks));
          if (results.last !== want.last)
            report($sformatf("last %0b, expected %0b", results.last, want.last));
        end
      end
    end
  end

endmodule

/* sim/sleep_deadline_queue_test.sv */
// Testbench top of the sleep deadline queue: clock, stimulus, APB setup and verdict.
`timescale 1ns / 100ps
module sleep_deadline_queue_test;
  import sdq_pkg::*;

  localparam int DRAIN_CYCLES = 400;      // front conversion plus a full scan, with margin
  localparam int CYCLE_LIMIT  = 2000000;

  logic                  clk;
  logic                  rst;
  logic                  psel, penable, pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  int                    errors, pending;
  int                    cycles;
  int                    hold_off;        // long receiver stall, consumed by the ready process
  logic [63:0]           epoch;           // rolling time base for random requests

  sdq_item_if   items();
  sdq_result_if results();

  sleep_deadline_queue u_top (
    .clk(clk), .rst(rst), .items(items), .results(results),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  sdq_checker u_checker (
    .clk(clk), .rst(rst), .items(items), .results(results),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata), .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // watchdog
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("[sleep_deadline_queue] ERROR");
        $finish;
      end
    end
  end

  // APB write: setup cycle, then access cycle; register lands when penable is high
  task automatic reg_write(input logic [APB_ADDR_W-1:0] addr, input logic [63:0] data);
    @(negedge clk);
    psel = 1'b1; pwrite = 1'b1; penable = 1'b0; paddr = addr; pwdata = data;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  // wait for all events, then give the block its latency before touching registers
  task automatic drain;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic setup(input logic [FREQ_W-1:0] freq, input logic qen);
    drain();
    reg_write(4'(8 * REG_FREQ), 64'(freq));
    reg_write(4'(8 * REG_QEN), 64'(qen));
  endtask

  // offer one request after a gap; valid stays high across back-to-back requests
  task automatic send_request(input int gap, input logic [KIND_W-1:0] kind,
                              input logic [TASK_W-1:0] t, input logic [63:0] now,
                              input logic [DUR_W-1:0] dur, input logic [SEC_W-1:0] secs);
    @(negedge clk);
    if (gap > 0) begin
      items.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    items.kind = kind; items.task_id = t; items.now_ticks = now;
    items.duration = dur; items.whole_seconds = secs;
    items.valid = 1'b1;
    @(posedge clk);
    while (!items.ready) @(posedge clk);
  endtask

  task automatic end_requests;
    @(negedge clk);
    items.valid = 1'b0;
  endtask

  // random request, mostly sleeps and scans around a moving time base
  task automatic random_request(input bit bursty);
    int          sel, gap;
    logic [63:0] now;
    logic [15:0] t;
    logic [31:0] dur;
    logic [19:0] secs;
    sel  = $urandom_range(0, 99);
    gap  = bursty ? 0 : $urandom_range(0, 19);
    t    = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 7));
    secs = '0;
    epoch = epoch + 64'($urandom_range(0, 200000));
    now  = epoch;
    if (sel < 3) now = {$urandom, $urandom};      // noise across the full time range
    if (sel < 35) begin
      dur = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 500);
      send_request(gap, KIND_SLEEP_US, t, now, dur, secs);
    end else if (sel < 65) begin
      dur = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 2000000);
      if ($urandom_range(0, 9) == 0) secs = 20'($urandom);
      send_request(gap, KIND_SLEEP_NS, t, now, dur, secs);
    end else if (sel < 88) begin
      send_request(gap, KIND_SCAN, t, now, $urandom, 20'($urandom));
    end else begin
      send_request(gap, KIND_DETACH, t, now, $urandom, 20'($urandom));
    end
  endtask

  // result side: random per-request gaps, bursts with none, one long hold-off
  initial begin
    bit fast;
    int gap;
    fast = 1'b0;
    results.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_off > 0) begin
        results.ready = 1'b0;
        repeat (hold_off) @(negedge clk);
        hold_off = 0;
      end
      if ($urandom_range(0, 29) == 0) fast = !fast;
      gap = fast ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
        results.ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      results.ready = 1'b1;
      @(posedge clk);
      while (!(results.valid && results.ready)) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin
    bit burst;
    rst = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    items.valid = 1'b0; items.kind = KIND_SCAN; items.task_id = '0;
    items.now_ticks = '0; items.duration = '0; items.whole_seconds = '0;
    hold_off = 0;
    epoch = 64'd1000;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed, reset settings: empty scan, unknown detach, extremes, saturation
    send_request(0, KIND_SCAN, 16'd0, 64'd0, '0, '0);
    send_request(2, KIND_DETACH, 16'hFFFF, '1, '1, '1);
    send_request(0, KIND_SLEEP_US, 16'd1, 64'd0, 32'd0, '0);
    send_request(1, KIND_SLEEP_US, 16'hFFFF, 64'd5, 32'hFFFF_FFFF, '1);
    send_request(0, KIND_SLEEP_NS, 16'd3, 64'd100, 32'd999999, '0);   // fine sleep, arms
    send_request(0, KIND_SLEEP_NS, 16'd4, 64'd100, 32'd1000000, '0);  // exactly 1 ms, not fine
    send_request(0, KIND_SLEEP_NS, 16'd5, '1, 32'hFFFF_FFFF, '1);     // deadline saturates
    send_request(3, KIND_SCAN, 16'd0, 64'd1000, '0, '0);               // fine entry re-arms
    send_request(0, KIND_DETACH, 16'd4, 64'd0, '0, '0);
    // fill the table with duplicate ids, overflow once
    for (int k = 0; k < 13; k++)
      send_request(0, KIND_SLEEP_NS, 16'(k % 3), 64'd2000, 32'(k * 1000), '0);
    send_request(0, KIND_SLEEP_US, 16'd9, 64'd0, 32'd1, '0);           // table full
    send_request(0, KIND_DETACH, 16'd1, 64'd0, '0, '0);                // first duplicate
    send_request(0, KIND_SCAN, 16'd0, '1, '0, '0);                     // wakes everything
    end_requests();

    // queueing disabled
    setup(34'd1000000000, 1'b0);
    send_request(0, KIND_SLEEP_US, 16'd7, 64'd10, 32'd10, '0);
    send_request(0, KIND_SLEEP_NS, 16'd8, 64'd10, 32'd10, '0);
    end_requests();

    // zero, lowest and highest frequencies
    setup(34'd0, 1'b1);
    send_request(0, KIND_SLEEP_US, 16'd1, 64'd50, 32'hFFFF_FFFF, '0);
    send_request(0, KIND_SLEEP_NS, 16'd2, 64'd50, 32'd10, '0);
    send_request(0, KIND_SCAN, 16'd0, 64'd50, '0, '0);
    end_requests();
    setup(34'd1, 1'b1);
    for (int k = 0; k < 20; k++) random_request(1'b0);
    end_requests();
    setup(34'h3_FFFF_FFFF, 1'b1);
    send_request(0, KIND_SLEEP_NS, 16'd3, 64'd0, 32'd999999, '0);
    send_request(0, KIND_SLEEP_US, 16'd4, 64'd0, 32'hFFFF_FFFF, '0);
    send_request(0, KIND_SLEEP_NS, 16'd5, 64'd0, 32'hFFFF_FFFF, '1);
    send_request(0, KIND_SCAN, 16'd0, 64'd10, '0, '0);
    for (int k = 0; k < 20; k++) random_request(1'b0);
    send_request(0, KIND_SCAN, 16'd0, '1, '0, '0);
    end_requests();

    // main random phase at the usual frequency; stall results early so input backs up
    setup(34'd1000000000, 1'b1);
    hold_off = 3000;
    burst = 1'b0;
    for (int k = 0; k < 250; k++) begin
      if ($urandom_range(0, 24) == 0) burst = !burst;
      random_request(burst);
    end
    end_requests();

    // a random frequency, then queueing off mid-run
    setup(34'({$urandom, $urandom}), 1'b1);
    for (int k = 0; k < 40; k++) random_request(1'b0);
    end_requests();
    setup(34'd1000000, 1'b0);
    for (int k = 0; k < 20; k++) random_request(1'b0);
    end_requests();

    drain();
    if (errors == 0) begin
      $display("[sleep_deadline_queue] OK");
    end else begin
      $display("[sleep_deadline_queue] ERROR");
    end
    $finish;
  end

endmodule
